FILE: sv/mmns_pkg.sv
package mmns_pkg;

  localparam int MaxEntries = 32;
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int IdxW = $clog2(MaxEntries);

  localparam logic [1:0] ModeRaw = 2'd0;

  typedef struct packed {
    logic signed [15:0] confidence;
    logic [15:0]        item_id;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] key_out;
    logic [15:0]        id_out;
    logic               last_out;
    logic               overflow;
  } out_item_t;

  // one sorted slot of the insertion chain
  typedef struct packed {
    logic               vld;
    logic signed [16:0] key;
    logic [15:0]        id;
  } slot_t;

endpackage

FILE: sv/minmax_normalize_sort_table_unit.sv
// Min/max normalize and descending sort. A set of pairs is loaded one transaction
// per cycle through start/busy, closed by last_in. In mode 0 the raw keys are
// insertion-sorted in a chain of MaxEntries cells as they arrive, so the close
// costs no sorting time: the sorted run drains one result per cycle, with busy
// high until it has drained; the first result is registered in out_item once
// the state register has entered drain. In modes 1, 2 and 3 the keys are also
// kept in a small memory in arrival order; after the close each one is read,
// normalized by a 17-step bit-serial divider and inserted into the chain in
// arrival order, one key at a time (read, divider start, 17 steps, insert).
// Busy stays high through these steps and the drain before a new set can start.
// Results appear on out_valid for exactly one cycle each and cannot be held off.
// Pairs beyond capacity are dropped and flagged on every result of the set.
module minmax_normalize_sort_table_unit import mmns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_data
);

  typedef enum logic [2:0] {ST_LOAD, ST_RD, ST_DIV, ST_WAIT, ST_DRAIN} state_t;

  state_t state_r;
  logic [1:0] mode_r;
  logic [CntW-1:0] cnt_r, pos_r;
  logic signed [15:0] min_r, max_r;
  logic drop_r;
  logic signed [15:0] kmem [MaxEntries];
  logic [15:0] imem [MaxEntries];
  logic signed [15:0] rk_r;
  logic [15:0] ri_r;
  logic out_valid_r;
  out_item_t out_r;

  slot_t slots [MaxEntries];
  logic  takes [MaxEntries];
  slot_t new_slot;
  logic  ins, drain, clr;
  logic  accept, store;

  logic div_go, div_done;
  logic [16:0] div_q;

  assign accept = start && !busy;
  assign store  = accept && (cnt_r < CntW'(MaxEntries));
  assign busy   = (state_r != ST_LOAD);

  // raw mode inserts on arrival; normalizing modes insert divider results
  assign ins = (mode_r == ModeRaw) ? store : div_done;
  assign new_slot.vld = 1'b1;
  assign new_slot.key = (mode_r == ModeRaw) ? {in_item.confidence[15], in_item.confidence}
                                            : div_q;
  assign new_slot.id  = (mode_r == ModeRaw) ? in_item.item_id : ri_r;
  assign drain = (state_r == ST_DRAIN);
  assign clr = 1'b0;
  assign div_go = (state_r == ST_DIV);

  for (genvar g = 0; g < MaxEntries; g++) begin : g_chain
    slot_t prev_s, next_s;
    logic  prev_t;
    if (g == 0) begin : g_head
      assign prev_s = '0;
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_s = slots[g-1];
      assign prev_t = takes[g-1];
    end
    if (g == MaxEntries - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_mid
      assign next_s = slots[g+1];
    end
    mmns_cell u_cell (
      .clk, .rst_n, .clr, .ins, .drain,
      .new_slot, .prev_slot(prev_s), .prev_take(prev_t), .next_slot(next_s),
      .slot(slots[g]), .take(takes[g])
    );
  end

  // key - min always fits 16 bits unsigned
  mmns_norm u_norm (
    .clk, .rst_n,
    .go(div_go),
    .diff({1'b0, 16'(rk_r - min_r)}),
    .range(17'({max_r[15], max_r} - {min_r[15], min_r})),
    .invert(mode_r[1] | mode_r[0] & mode_r[1]),
    .done(div_done),
    .q(div_q)
  );

  always_ff @(posedge clk) begin
    if (store) begin
      kmem[cnt_r[IdxW-1:0]] <= in_item.confidence;
      imem[cnt_r[IdxW-1:0]] <= in_item.item_id;
    end
    rk_r <= kmem[pos_r[IdxW-1:0]];
    ri_r <= imem[pos_r[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; mode_r <= ModeRaw; cnt_r <= '0; pos_r <= '0;
      min_r <= 16'sh7FFF; max_r <= -16'sh8000; drop_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) mode_r <= cfg_data;
      unique case (state_r)
        ST_LOAD: begin
          if (accept) begin
            if (store) begin
              cnt_r <= cnt_r + CntW'(1);
              if (in_item.confidence < min_r) min_r <= in_item.confidence;
              if (in_item.confidence > max_r) max_r <= in_item.confidence;
            end else begin
              drop_r <= 1'b1;
            end
            pos_r <= '0;
            if (in_item.last_in) begin
              state_r <= (mode_r == ModeRaw) ? ST_DRAIN : ST_RD;
            end
          end
        end
        ST_RD: state_r <= (pos_r == cnt_r) ? ST_DRAIN : ST_DIV;
        ST_DIV: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            pos_r <= pos_r + CntW'(1);
            state_r <= ST_RD;
          end
        end
        ST_DRAIN: begin
          if (slots[0].vld) begin
            out_valid_r <= 1'b1;
            out_r.key_out  <= slots[0].key;
            out_r.id_out   <= slots[0].id;
            out_r.last_out <= !slots[1].vld;
            out_r.overflow <= drop_r;
          end else begin
            state_r <= ST_LOAD; cnt_r <= '0;
            min_r <= 16'sh7FFF; max_r <= -16'sh8000; drop_r <= 1'b0;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

FILE: sv/mmns_cell.sv
// One slot of a descending insertion chain. A new entry goes in front of the
// first strictly smaller key; entries behind it shift one place down.
// During drain the chain shifts up toward cell 0.
module mmns_cell import mmns_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  clr,
  input  logic  ins,
  input  logic  drain,
  input  slot_t new_slot,
  input  slot_t prev_slot,   // cell above (toward head)
  input  logic  prev_take,   // cell above keeps the new entry or passes its old one
  input  slot_t next_slot,   // cell below, for drain
  output slot_t slot,
  output logic  take
);

  slot_t slot_r, slot_nxt;

  // the new entry lands in this cell or in one above it
  assign take = !slot_r.vld || (slot_r.key < new_slot.key);
  assign slot = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (clr) begin
      slot_nxt.vld = 1'b0;
    end else if (drain) begin
      slot_nxt = next_slot;
    end else if (ins) begin
      if (prev_take) slot_nxt = prev_slot;
      else if (take) slot_nxt = new_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.vld <= 1'b0;
      slot_r.key <= '0;
      slot_r.id  <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

FILE: sv/mmns_norm.sv
// Restoring divider: floor((k - min) << 16 / range), one quotient bit per cycle,
// saturated and optionally inverted.
module mmns_norm import mmns_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [16:0] diff,    // k - min, 0..65535
  input  logic [16:0] range,   // max - min
  input  logic        invert,
  output logic        done,
  output logic [16:0] q
);

  logic [33:0] rem_r, rem_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [34:0] trial;
  logic [15:0] sat;

  assign trial = {rem_r, 1'b0} - {1'b0, range, 17'd0};
  assign sat = (range == 17'd0) ? 16'd0 : ((|quo_r[16]) ? 16'hFFFF : quo_r[15:0]);
  assign q = {1'b0, invert ? 16'hFFFF - sat : sat};
  assign done = done_r;

  always_comb begin
    rem_nxt = rem_r; quo_nxt = quo_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (go) begin
      rem_nxt = {1'b0, diff, 16'd0};
      quo_nxt = '0; cnt_nxt = 5'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[34]) begin
        rem_nxt = trial[33:0]; quo_nxt = {quo_r[15:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[32:0], 1'b0}; quo_nxt = {quo_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; quo_r <= quo_nxt;
  end

endmodule

FILE: dv/minmax_normalize_sort_table_unit_test.sv
module minmax_normalize_sort_table_unit_test;
  import mmns_pkg::*;

  // Mode codes for the one config register; only raw is exported by the package.
  localparam logic [1:0] ModeNorm    = 2'd1;
  localparam logic [1:0] ModeNormInv = 2'd2;
  localparam logic [1:0] ModeSpare   = 2'd3;  // behaves like normalize+invert

  localparam int CycleLimit = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  logic      cfg_we;
  logic [1:0] cfg_data;

  minmax_normalize_sort_table_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predictor state: the open set, its running extremes and the mode.
  logic signed [15:0] set_keys [MaxEntries];
  logic [15:0]        set_ids  [MaxEntries];
  int                 set_count;
  logic signed [15:0] set_min;
  logic signed [15:0] set_max;
  logic               set_dropped;
  logic [1:0]         cur_mode;

  out_item_t sorted_q [$];  // expected results, oldest first
  int        mismatches;
  int        cycles;
  bit        timed_out;

  function automatic void clear_set();
    set_count   = 0;
    set_min     = 16'sh7fff;
    set_max     = -16'sh8000;
    set_dropped = 1'b0;
  endfunction

  // append one expected result at the tail
  function automatic void queue_expected(out_item_t r);
    sorted_q = {sorted_q, r};
  endfunction

  // floor((k - min) * 65536 / range), saturated to 16 bits; zero range gives 0
  function automatic logic signed [16:0] scaled_key(logic signed [15:0] k);
    longint rng;
    longint q;
    rng = longint'(set_max) - longint'(set_min);
    if (rng == 0) return 17'sd0;
    q = ((longint'(k) - longint'(set_min)) * 65536) / rng;
    if (q > 65535) q = 65535;
    return 17'(q);
  endfunction

  // Absorb one accepted transaction; on close, queue the sorted run.
  function automatic void predict_sort(in_item_t it);
    logic signed [16:0] keys [MaxEntries];
    logic [15:0]        ids  [MaxEntries];
    logic signed [16:0] k;
    out_item_t          r;
    int                 j;
    if (set_count < MaxEntries) begin
      set_keys[set_count] = it.confidence;
      set_ids[set_count]  = it.item_id;
      set_count++;
      if (it.confidence < set_min) set_min = it.confidence;
      if (it.confidence > set_max) set_max = it.confidence;
    end else begin
      set_dropped = 1'b1;
    end
    if (!it.last_in) return;
    for (int i = 0; i < set_count; i++) begin
      if (cur_mode == ModeRaw) begin
        k = 17'(set_keys[i]);
      end else begin
        k = scaled_key(set_keys[i]);
        if (cur_mode != ModeNorm) k = 17'sd65535 - k;
      end
      // stable descending insertion: only pass strictly smaller keys
      j = i;
      while (j > 0 && keys[j-1] < k) begin
        keys[j] = keys[j-1];
        ids[j]  = ids[j-1];
        j--;
      end
      keys[j] = k;
      ids[j]  = set_ids[i];
    end
    for (int i = 0; i < set_count; i++) begin
      r.key_out  = keys[i];
      r.id_out   = ids[i];
      r.last_out = (i == set_count - 1);
      r.overflow = set_dropped;
      queue_expected(r);
    end
    clear_set();
  endfunction

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: key %0d id %0d",
                   out_item.key_out, out_item.id_out);
      end else begin
        out_item_t e;
        e = sorted_q.pop_front();
        if (out_item !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp key %0d id %0h last %0b ovf %0b,",
                      " got key %0d id %0h last %0b ovf %0b"},
                     e.key_out, e.id_out, e.last_out, e.overflow,
                     out_item.key_out, out_item.id_out, out_item.last_out,
                     out_item.overflow);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly short gaps, occasionally a long one, sometimes none.
  // start drops only when a gap follows.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 9);
    if (n < 4) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Send one transaction; start stays up until an edge with busy low.
  task automatic send_pair(logic signed [15:0] conf, logic [15:0] id, logic last);
    in_item_t it;
    it.confidence = conf;
    it.item_id    = id;
    it.last_in    = last;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_sort(it);
    idle_gap();
  endtask

  // Wait for the sorted run to drain plus slack for any divider tail.
  task automatic drain_results();
    start <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (40 * MaxEntries) @(posedge clk);
  endtask

  // Change mode only while idle.
  task automatic set_mode(logic [1:0] m);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode  = m;
  endtask

  task automatic send_set(int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      send_pair(16'($urandom_range(lo, hi) - 32768), 16'($urandom), i == n - 1);
  endtask

  // Field extremes, ties, single entry and all-equal keys.
  task automatic test_directed();
    send_pair(16'sh7fff, 16'hffff, 1'b0);
    send_pair(-16'sh8000, 16'h0000, 1'b0);
    send_pair(16'sd0, 16'h5555, 1'b0);
    send_pair(16'sd0, 16'haaaa, 1'b0);
    send_pair(-16'sd1, 16'h0001, 1'b1);
    send_pair(16'sd5, 16'h1234, 1'b1);
    for (int i = 0; i < 4; i++) send_pair(16'sd77, 16'(i), i == 3);
  endtask

  // More than MaxEntries pairs: extras dropped, flag on every result; then a full set.
  task automatic test_overflow();
    send_set(MaxEntries + 3, 0, 65535);
    send_set(MaxEntries, 0, 65535);
  endtask

  // Random sets, mostly small; ties made likely by narrow ranges.
  task automatic test_random(int pairs);
    int n;
    while (pairs > 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MaxEntries + 2)
                                      : $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) send_set(n, 32760, 32775);
      else send_set(n, 0, 65535);
      pairs -= n;
    end
  endtask

  task automatic test_pause_until_drained();
    send_set(6, 0, 65535);
    start <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    send_set(3, 0, 65535);
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_item  = '0;
    cfg_we   = 1'b0;
    cfg_data = ModeRaw;
    cur_mode = ModeRaw;
    mismatches = 0;
    cycles     = 0;
    timed_out  = 1'b0;
    clear_set();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random(60);
    test_pause_until_drained();
    set_mode(ModeNorm);
    test_directed();
    test_random(60);
    set_mode(ModeNormInv);
    test_directed();
    test_overflow();
    test_random(60);
    set_mode(ModeSpare);
    test_directed();
    test_random(30);
    set_mode(ModeRaw);
    test_random(30);
    drain_results();

    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mmns_pkg.sv
sv/mmns_cell.sv
sv/mmns_norm.sv
sv/minmax_normalize_sort_table_unit.sv
dv/minmax_normalize_sort_table_unit_test.sv
